>>> hdl/krt_pkg.sv
// Shared types and codes for the keyed record table.
// Used by krt_ctrl, krt_datapath and keyed_record_table; depends on nothing.
`default_nettype none

package krt_pkg;

    localparam int OP_W      = 16;
    localparam int MACH_W    = 8;
    localparam int TIME_W    = 16;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int HELD_W    = 7;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT      = 3'd0,
        KIND_UPDATE      = 3'd1,
        KIND_DEL_OP      = 3'd2,
        KIND_DEL_MACHINE = 3'd3,
        KIND_SEARCH      = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_MISSING   = 2'd3
    } status_t;

    // One table slot as it sits in the memory.
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [MACH_W-1:0] mach;
        logic [TIME_W-1:0] rt;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic addr_clr;
        logic addr_inc;
        logic rd_en;
        logic load_req;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic addr_last;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

>>> hdl/krt_ctrl.sv
// Sequencing state machine of the keyed record table: clearing pass, scan, commit.
// Depends on krt_pkg.
`default_nettype none

module krt_ctrl
    import krt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.addr_inc = 1'b1;
                if (sts.addr_last)
                begin
                    cmd.addr_clr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.addr_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_inc = 1'b1;
                if (sts.addr_last)
                begin
                    cmd.addr_clr = 1'b1;
                    state_next   = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // Wait here while the previous result has not been taken.
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/krt_datapath.sv
// Datapath of the keyed record table: slot memory, scan compare stage, record count
// and result register. Depends on krt_pkg.
`default_nettype none

module krt_datapath
    import krt_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    input  wire logic [KIND_W-1:0]     req_kind,
    input  wire logic [OP_W-1:0]       req_op,
    input  wire logic [MACH_W-1:0]     req_mach,
    input  wire logic [TIME_W-1:0]     req_rt,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [STATUS_W-1:0]        out_status,
    output logic [TIME_W-1:0]          out_found,
    output logic [HELD_W-1:0]          out_held
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    entry_t            mem [CAPACITY];

    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     cmp_addr_reg;
    logic              cmp_valid_reg;
    entry_t            rd_data_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [OP_W-1:0]   op_reg;
    logic [MACH_W-1:0] mach_reg;
    logic [TIME_W-1:0] rt_reg;

    logic              hit_found_reg;
    logic [AW-1:0]     hit_idx_reg;
    logic [TIME_W-1:0] hit_rt_reg;
    logic              free_found_reg;
    logic [AW-1:0]     free_idx_reg;
    logic              removed_reg;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    logic              out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [TIME_W-1:0] found_reg;
    logic [HELD_W-1:0] held_reg;

    logic              pair_hit;
    logic              del_hit;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_data;
    status_t           commit_status;
    logic [TIME_W-1:0] commit_found;
    entry_t            new_entry;

    assign sts.addr_last = (addr_reg == AW'(CAPACITY - 1));
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign new_entry = '{valid: 1'b1, op: op_reg, mach: mach_reg, rt: rt_reg};

    // Key compare on the slot read in the previous cycle.
    assign pair_hit = cmp_valid_reg && rd_data_reg.valid
                      && (rd_data_reg.op == op_reg) && (rd_data_reg.mach == mach_reg);
    assign del_hit  = cmp_valid_reg && rd_data_reg.valid
                      && (((kind_reg == KIND_DEL_OP) && (rd_data_reg.op == op_reg))
                       || ((kind_reg == KIND_DEL_MACHINE) && (rd_data_reg.mach == mach_reg)));

    // Outcome of the request once the scan is over.
    always_comb
    begin
        commit_status = ST_MISSING;
        commit_found  = '0;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = '0;
        count_next    = count_reg;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (hit_found_reg)
                begin
                    commit_status = ST_DUPLICATE;
                end
                else if (free_found_reg)
                begin
                    commit_status = ST_OK;
                end
                else
                begin
                    commit_status = ST_FULL;
                end
            end
            KIND_UPDATE:
            begin
                if (hit_found_reg)
                begin
                    commit_status = ST_OK;
                end
            end
            KIND_DEL_OP, KIND_DEL_MACHINE:
            begin
                if (removed_reg)
                begin
                    commit_status = ST_OK;
                end
            end
            KIND_SEARCH:
            begin
                if (hit_found_reg)
                begin
                    commit_status = ST_OK;
                    commit_found  = hit_rt_reg;
                end
            end
            default:
            begin
                commit_status = ST_MISSING;
            end
        endcase

        // The single write port is shared in time by clearing, deletion and commit.
        if (cmd.clear_wr)
        begin
            wr_en = 1'b1;
        end
        else if (del_hit)
        begin
            wr_en         = 1'b1;
            wr_addr       = cmp_addr_reg;
            wr_data       = rd_data_reg;
            wr_data.valid = 1'b0;
            count_next    = count_reg - 1'b1;
        end
        else if (cmd.commit && (kind_reg == KIND_INSERT) && (commit_status == ST_OK))
        begin
            wr_en      = 1'b1;
            wr_addr    = free_idx_reg;
            wr_data    = new_entry;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.commit && (kind_reg == KIND_UPDATE) && (commit_status == ST_OK))
        begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_reg;
            wr_data = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            cmp_valid_reg  <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            removed_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.addr_clr)
            begin
                addr_reg <= '0;
            end
            else if (cmd.addr_inc)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            cmp_valid_reg <= cmd.rd_en;
            count_reg     <= count_next;

            if (cmd.load_req)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                removed_reg    <= 1'b0;
            end
            else if (cmp_valid_reg)
            begin
                if (pair_hit && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!rd_data_reg.valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (del_hit)
                begin
                    removed_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request fields, match positions and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg <= req_kind;
            op_reg   <= req_op;
            mach_reg <= req_mach;
            rt_reg   <= req_rt;
        end
        if (pair_hit && !hit_found_reg)
        begin
            hit_idx_reg <= cmp_addr_reg;
            hit_rt_reg  <= rd_data_reg.rt;
        end
        if (cmp_valid_reg && !rd_data_reg.valid && !free_found_reg)
        begin
            free_idx_reg <= cmp_addr_reg;
        end
        cmp_addr_reg <= addr_reg;
        if (cmd.commit)
        begin
            status_reg <= commit_status;
            found_reg  <= commit_found;
            held_reg   <= HELD_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_found  = found_reg;
    assign out_held   = held_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("record count exceeds the table capacity");

    a_compare_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> cmp_valid_reg)
        else $error("compare stage did not follow a slot read");

    a_commit_presents: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed request did not present a result");

    a_no_commit_over_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("commit would overwrite a result not yet taken");

endmodule

`default_nettype wire

>>> hdl/keyed_record_table.sv
// Top level of the keyed record table: stream ports, controller and datapath.
// Depends on krt_pkg, krt_ctrl and krt_datapath.
//
// The keyed record table holds up to CAPACITY records, each keyed by an operation id
// and a machine id and carrying a 16-bit runtime. A request arrives as one transfer on
// the slave stream (the request kind on s_tuser) and produces exactly one result
// transfer on the master stream: a status code, the runtime found by a search (zero
// otherwise) and the number of records held afterwards. After reset the block first
// runs a clearing pass over the slot memory, one slot per cycle, during which s_tready
// stays low. The slots live in a memory with one write port and one registered read
// port, so one write and one registered read per cycle; every request reads every
// slot once in order, then does the last compare in the drain state and the commit in
// the commit state. A request is taken only in the idle state, so no new request is
// accepted before the last one is committed. The next request is accepted as soon as
// the commit is done, even if the result still waits on m_tready; a second commit
// waits until the earlier result has been taken. Inserts take the lowest-numbered free
// slot, duplicates are refused before fullness is checked, and deletes remove every
// matching record in the same scan.
`default_nettype none

module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata, from bit 0: op_id[15:0], machine_id[23:16], run_time[39:24]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // s_tuser: kind[2:0]
    input  wire logic [KIND_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata, from bit 0: status[1:0], found_time[17:2], held_count[24:18], zeros above
    output logic [M_DATA_W-1:0]       m_tdata
);

    cmd_t                cmd;
    sts_t                sts;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   found_time;
    logic [HELD_W-1:0]   held_count;

    krt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    krt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_kind   (s_tuser),
        .req_op     (s_tdata[15:0]),
        .req_mach   (s_tdata[23:16]),
        .req_rt     (s_tdata[39:24]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (status),
        .out_found  (found_time),
        .out_held   (held_count)
    );

    // Fields packed from the lowest bit up; the top seven bits are padding.
    assign m_tdata = {7'd0, held_count, found_time, status};

endmodule

`default_nettype wire
